>>> rtl/ddr_read_phase_window_finder_top_defines.svh
// ----------------------------------------------------------------------------
// Read phase window finder: assertion macros
// Shared concurrent assertion shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DDR_READ_PHASE_WINDOW_FINDER_TOP_DEFINES_SVH
`define DDR_READ_PHASE_WINDOW_FINDER_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define RPWF_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define RPWF_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/rpwf_pkg.sv
// ----------------------------------------------------------------------------
// Read phase window finder package
// Shared widths, register indexes, verdict codes and bundle types.
// ----------------------------------------------------------------------------
package rpwf_pkg;

  localparam int PHASES    = 160;
  localparam int SCORE_W   = 4;
  localparam int PHASE_W   = 8;
  localparam int SUM_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERFECT    = 2'd2;

  localparam logic [SCORE_W-1:0] THRESHOLD_RST  = 4'd14;
  localparam logic [PHASE_W-1:0] MIN_WINDOW_RST = 8'd8;
  localparam logic [SUM_W-1:0]   PERFECT_RST    = 12'd2400;

  typedef enum logic [1:0] {
    VERDICT_NO_WINDOW  = 2'd0,
    VERDICT_TOO_NARROW = 2'd1,
    VERDICT_ACCEPTED   = 2'd2,
    VERDICT_SIMULATION = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [SCORE_W-1:0] good_threshold;
    logic [PHASE_W-1:0] min_window;
    logic [SUM_W-1:0]   perfect_total;
  } cfg_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [PHASE_W-1:0] center_phase;
    logic [PHASE_W-1:0] window_length;
    logic [SUM_W-1:0]   total_score;
  } result_t;

endpackage

>>> rtl/rpwf_cfg_regs.sv
// ----------------------------------------------------------------------------
// Read phase window finder configuration registers
// Write-only register file for threshold, minimum window and perfect total.
// ----------------------------------------------------------------------------
module rpwf_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [rpwf_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [rpwf_pkg::CFG_DAT_W-1:0] wr_data,
  output rpwf_pkg::cfg_t                 cfg
);

  rpwf_pkg::cfg_t cfg_r;
  rpwf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        rpwf_pkg::CFG_IDX_THRESHOLD:
          cfg_nxt.good_threshold = wr_data[rpwf_pkg::SCORE_W-1:0];
        rpwf_pkg::CFG_IDX_MIN_WINDOW:
          cfg_nxt.min_window = wr_data[rpwf_pkg::PHASE_W-1:0];
        rpwf_pkg::CFG_IDX_PERFECT:
          cfg_nxt.perfect_total = wr_data[rpwf_pkg::SUM_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.good_threshold <= rpwf_pkg::THRESHOLD_RST;
      cfg_r.min_window     <= rpwf_pkg::MIN_WINDOW_RST;
      cfg_r.perfect_total  <= rpwf_pkg::PERFECT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/rpwf_sweep.sv
// ----------------------------------------------------------------------------
// Read phase window finder sweep tracker
// Per-phase run tracking, best window, score sum and end-of-sweep verdict.
// ----------------------------------------------------------------------------
`include "ddr_read_phase_window_finder_top_defines.svh"

module rpwf_sweep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [rpwf_pkg::SCORE_W-1:0] score,
  input  logic                         last,
  input  rpwf_pkg::cfg_t               cfg,
  output logic                         final_step,
  output rpwf_pkg::result_t            result
);

  logic [rpwf_pkg::PHASE_W-1:0] phase_r,  phase_nxt;
  logic                         open_r,   open_nxt;
  logic [rpwf_pkg::PHASE_W-1:0] start_r,  start_nxt;
  logic [rpwf_pkg::PHASE_W-1:0] blen_r,   blen_nxt;
  logic [rpwf_pkg::PHASE_W-1:0] bctr_r,   bctr_nxt;
  logic [rpwf_pkg::SUM_W-1:0]   sum_r,    sum_nxt;

  logic                         good;
  logic [rpwf_pkg::PHASE_W-1:0] run_len;
  logic                         open_upd;
  logic [rpwf_pkg::PHASE_W-1:0] start_upd;
  logic [rpwf_pkg::PHASE_W-1:0] len_upd;
  logic [rpwf_pkg::PHASE_W-1:0] ctr_upd;
  logic [rpwf_pkg::SUM_W-1:0]   sum_upd;

  assign good       = (score >= cfg.good_threshold);
  assign run_len    = phase_r - start_r;
  assign sum_upd    = sum_r + rpwf_pkg::SUM_W'(score);
  assign final_step = last ||
                      (phase_r >= rpwf_pkg::PHASE_W'(rpwf_pkg::PHASES - 1));

  // Close the run on a bad phase; keep only a strictly longer run.
  always_comb begin
    open_upd = open_r;
    start_upd = start_r;
    len_upd = blen_r;
    ctr_upd = bctr_r;
    if (!open_r && good) begin
      start_upd = phase_r;
      open_upd  = 1'b1;
    end else if (open_r && !good) begin
      open_upd = 1'b0;
      if (run_len > blen_r) begin
        len_upd = run_len;
        ctr_upd = start_r + (run_len >> 1);
      end
    end
  end

  always_comb begin
    result.center_phase  = ctr_upd;
    result.window_length = len_upd;
    result.total_score   = sum_upd;
    if (sum_upd == cfg.perfect_total) begin
      result.verdict = rpwf_pkg::VERDICT_SIMULATION;
    end else if (len_upd == '0) begin
      result.verdict = rpwf_pkg::VERDICT_NO_WINDOW;
    end else if (len_upd < cfg.min_window) begin
      result.verdict = rpwf_pkg::VERDICT_TOO_NARROW;
    end else begin
      result.verdict = rpwf_pkg::VERDICT_ACCEPTED;
    end
  end

  // Clear the sweep after the final step.
  always_comb begin
    if (final_step) begin
      phase_nxt = '0;
      open_nxt  = 1'b0;
      start_nxt = '0;
      blen_nxt  = '0;
      bctr_nxt  = '0;
      sum_nxt   = '0;
    end else begin
      phase_nxt = phase_r + 1'b1;
      open_nxt  = open_upd;
      start_nxt = start_upd;
      blen_nxt  = len_upd;
      bctr_nxt  = ctr_upd;
      sum_nxt   = sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      open_r  <= 1'b0;
      start_r <= '0;
      blen_r  <= '0;
      bctr_r  <= '0;
      sum_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      open_r  <= open_nxt;
      start_r <= start_nxt;
      blen_r  <= blen_nxt;
      bctr_r  <= bctr_nxt;
      sum_r   <= sum_nxt;
    end
  end

  `RPWF_ASSERT_SAME(a_phase_range, 1'b1,
    phase_r <= rpwf_pkg::PHASE_W'(rpwf_pkg::PHASES - 1), "phase index past sweep end")
  `RPWF_ASSERT_NEXT(a_sweep_cleared, step && final_step,
    phase_r == '0 && !open_r && sum_r == '0, "sweep state not cleared after final step")
  `RPWF_ASSERT_SAME(a_no_window_center, blen_r == '0,
    bctr_r == '0, "center set without a window")

endmodule

>>> rtl/ddr_read_phase_window_finder_top.sv
// ----------------------------------------------------------------------------
// DDR read phase window finder, top level
// Finds the widest passing read-phase window of a sweep and grades it.
// ----------------------------------------------------------------------------
// Usage:
//   Send one input transaction per phase step of a read-clock sweep:
//   in_good_count is the number of passing reads at that phase and
//   in_last_phase marks the final step. A step at phase 159 ends the sweep
//   even without in_last_phase.
//   Only the final step of a sweep produces an output transaction carrying
//   the verdict (no window, too narrow, accepted, simulation), the center
//   and length of the longest closed run, and the summed score.
//   An accepted step is registered, processed by the tracker, and a final
//   step's result is registered in turn and presented on out_valid.
//   Throughput: one step per cycle through the tracker between the input
//   register and the result register, unless a final step is held back.
//   A held result stalls only a final step behind it; ordinary steps keep
//   flowing. in_ready drops only while a final step waits on a full result
//   register that out_ready does not drain.
//   Reset (rst_n low, synchronous) empties both registers, clears the sweep
//   and restores threshold 14, minimum window 8, perfect total 2400.
//   Write configuration through cfg_wr_en / cfg_index / cfg_wdata while
//   idle; unknown indexes are ignored.
// ----------------------------------------------------------------------------
`include "ddr_read_phase_window_finder_top_defines.svh"

module ddr_read_phase_window_finder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // step input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rpwf_pkg::SCORE_W-1:0]   in_good_count,
  input  logic                           in_last_phase,
  // sweep result
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_verdict,
  output logic [rpwf_pkg::PHASE_W-1:0]   out_center_phase,
  output logic [rpwf_pkg::PHASE_W-1:0]   out_window_length,
  output logic [rpwf_pkg::SUM_W-1:0]     out_total_score,
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [rpwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpwf_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  rpwf_pkg::cfg_t    cfg;
  rpwf_pkg::result_t sweep_res;

  // input register
  logic                         in_vld_r, in_vld_nxt;
  logic [rpwf_pkg::SCORE_W-1:0] in_score_r;
  logic                         in_last_r;

  // result register
  logic                         out_vld_r, out_vld_nxt;
  rpwf_pkg::result_t            out_res_r;

  logic in_fire;
  logic out_free;
  logic is_final;
  logic step;

  rpwf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  rpwf_sweep u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .score      (in_score_r),
    .last       (in_last_r),
    .cfg        (cfg),
    .final_step (is_final),
    .result     (sweep_res)
  );

  // The result slot is free when empty or being drained this cycle.
  assign out_free = !out_vld_r || out_ready;
  // Advance a held step; a final step also needs the result slot.
  assign step     = in_vld_r && (!is_final || out_free);
  assign in_ready = !in_vld_r || step;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    in_vld_nxt  = in_fire || (in_vld_r && !step);
    out_vld_nxt = (step && is_final) || (out_vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_score_r <= in_good_count;
      in_last_r  <= in_last_phase;
    end
    if (step && is_final) begin
      out_res_r <= sweep_res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_verdict       = out_res_r.verdict;
  assign out_center_phase  = out_res_r.center_phase;
  assign out_window_length = out_res_r.window_length;
  assign out_total_score   = out_res_r.total_score;

  `RPWF_ASSERT_SAME(a_final_needs_slot, step && is_final,
    out_free, "final step overwrote a pending result")
  `RPWF_ASSERT_NEXT(a_result_held, out_vld_r && !out_ready && !(step && is_final),
    out_vld_r && $stable(out_res_r), "pending result lost or changed")
  `RPWF_ASSERT_NEXT(a_ordinary_step_flows, in_vld_r && !is_final,
    !in_vld_r || $past(in_fire), "ordinary step was held back")

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Read phase window finder testbench
// Feeds phase-step scores over the valid/ready input, predicts each sweep
// verdict in step with every accepted transaction and checks the results in
// order, with random gaps on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [rpwf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;  // no register here
  localparam int SETTLE_CYCLES = 4;  // input and result registers plus margin

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [rpwf_pkg::SCORE_W-1:0]   in_good_count = '0;
  logic                           in_last_phase = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     out_verdict;
  logic [rpwf_pkg::PHASE_W-1:0]   out_center_phase;
  logic [rpwf_pkg::PHASE_W-1:0]   out_window_length;
  logic [rpwf_pkg::SUM_W-1:0]     out_total_score;
  logic                           cfg_wr_en = 1'b0;
  logic [rpwf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rpwf_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  // Shadow of the register file, starting at the reset values.
  logic [rpwf_pkg::SCORE_W-1:0]   thr_cfg     = rpwf_pkg::THRESHOLD_RST;
  logic [rpwf_pkg::PHASE_W-1:0]   minwin_cfg  = rpwf_pkg::MIN_WINDOW_RST;
  logic [rpwf_pkg::SUM_W-1:0]     perfect_cfg = rpwf_pkg::PERFECT_RST;

  // Shadow of the sweep tracker.
  logic [rpwf_pkg::PHASE_W-1:0]   sw_phase    = '0;
  logic                           sw_open     = 1'b0;
  logic [rpwf_pkg::PHASE_W-1:0]   sw_start    = '0;
  logic [rpwf_pkg::PHASE_W-1:0]   sw_best_len = '0;
  logic [rpwf_pkg::PHASE_W-1:0]   sw_best_mid = '0;
  logic [rpwf_pkg::SUM_W-1:0]     sw_sum      = '0;

  rpwf_pkg::result_t pending_results[$];

  int    mismatches    = 0;
  int    steps_sent    = 0;
  int    sweeps_graded = 0;
  int    cfg_writes    = 0;
  int    verdict_hits[4];
  bit    steady_feed   = 1'b0;
  int    sink_left     = 0;
  int    sink_pick;

  ddr_read_phase_window_finder_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_good_count     (in_good_count),
    .in_last_phase     (in_last_phase),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict),
    .out_center_phase  (out_center_phase),
    .out_window_length (out_window_length),
    .out_total_score   (out_total_score),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs: far above the slowest correct run.
  initial begin
    #6_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Advance the shadow tracker by one accepted step; on the final step of a
  // sweep, grade it, queue the expected result and clear the sweep.
  function automatic void advance_sweep(input logic [rpwf_pkg::SCORE_W-1:0] score,
                                        input logic last);
    logic [rpwf_pkg::PHASE_W-1:0] p;
    logic [rpwf_pkg::PHASE_W-1:0] len;
    rpwf_pkg::result_t            r;
    p = sw_phase;
    sw_sum = sw_sum + score;  // wraps at 12 bits like the hardware
    if (!sw_open && score >= thr_cfg) begin
      sw_start = p;
      sw_open  = 1'b1;
    end else if (sw_open && score < thr_cfg) begin
      // Close the run; only a strictly longer one replaces the best.
      len = p - sw_start;
      sw_open = 1'b0;
      if (len > sw_best_len) begin
        sw_best_len = len;
        sw_best_mid = sw_start + (len >> 1);
      end
    end
    // Phase PHASES-1 ends the sweep even without the last flag.
    if (!last && p < rpwf_pkg::PHASES - 1) begin
      sw_phase = p + 1'b1;
      return;
    end
    // Simulation wins over any window; an open run never counts.
    if (sw_sum == perfect_cfg) r.verdict = rpwf_pkg::VERDICT_SIMULATION;
    else if (sw_best_len == 0) r.verdict = rpwf_pkg::VERDICT_NO_WINDOW;
    else if (sw_best_len < minwin_cfg) r.verdict = rpwf_pkg::VERDICT_TOO_NARROW;
    else r.verdict = rpwf_pkg::VERDICT_ACCEPTED;
    r.center_phase  = sw_best_mid;
    r.window_length = sw_best_len;
    r.total_score   = sw_sum;
    pending_results.push_back(r);
    sw_phase    = '0;
    sw_open     = 1'b0;
    sw_start    = '0;
    sw_best_len = '0;
    sw_best_mid = '0;
    sw_sum      = '0;
  endfunction

  // Input gap: mostly back-to-back, some short holes, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_feed || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one step and hold it until the block takes it. Valid stays high
  // across back-to-back transactions; it only drops for a gap.
  task automatic send_step(input logic [rpwf_pkg::SCORE_W-1:0] score, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_good_count <= score;
    in_last_phase <= last;
    do @(posedge clk); while (!in_ready);
    advance_sweep(score, last);
    steps_sent++;
  endtask

  // Drop valid and wait until every queued result has been checked, then
  // let the pipeline empty of steps that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back while idle. Spare upper data bits
  // are randomized to check that the narrow registers ignore them.
  task automatic apply_config(input logic [rpwf_pkg::SCORE_W-1:0] th,
                              input logic [rpwf_pkg::PHASE_W-1:0] mw,
                              input logic [rpwf_pkg::SUM_W-1:0] pt);
    logic [rpwf_pkg::CFG_DAT_W-1:0] w;
    settle();
    w = rpwf_pkg::CFG_DAT_W'($urandom);
    w[rpwf_pkg::SCORE_W-1:0] = th;
    cfg_wr_en <= 1'b1;
    cfg_index <= rpwf_pkg::CFG_IDX_THRESHOLD;
    cfg_wdata <= w;
    @(posedge clk);
    w = rpwf_pkg::CFG_DAT_W'($urandom);
    w[rpwf_pkg::PHASE_W-1:0] = mw;
    cfg_index <= rpwf_pkg::CFG_IDX_MIN_WINDOW;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= rpwf_pkg::CFG_IDX_PERFECT;
    cfg_wdata <= pt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_cfg     = th;
    minwin_cfg  = mw;
    perfect_cfg = pt;
    cfg_writes += 3;
  endtask

  // Random sweep. A clean one looks like an eye: low scores, a passing run,
  // low scores again, with the odd glitch. A noisy one is random scores with
  // stray last flags, so sweeps split at odd places.
  task automatic send_eye_sweep(input int len, input bit noisy, input logic end_flag);
    bit                           in_eye;
    logic [rpwf_pkg::SCORE_W-1:0] g;
    logic                         l;
    in_eye = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        g = rpwf_pkg::SCORE_W'($urandom);
        l = ($urandom_range(0, 15) == 0);
      end else begin
        if (in_eye ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 3) == 0))
          in_eye = !in_eye;
        if (in_eye || thr_cfg == 0) g = rpwf_pkg::SCORE_W'($urandom_range(thr_cfg, 15));
        else g = rpwf_pkg::SCORE_W'($urandom_range(0, thr_cfg - 1));
        l = 1'b0;
      end
      if (i == len - 1) l = end_flag;
      send_step(g, l);
    end
  endtask

  // Close whatever sweep is half done so the next settings start clean.
  task automatic close_sweep();
    if (sw_phase != 0) send_step(rpwf_pkg::SCORE_W'($urandom), 1'b1);
  endtask

  // Reset values: a window exactly at the minimum, a tie that must not
  // replace the best, and a run left open at the end of the sweep.
  task automatic test_reset_defaults();
    logic [rpwf_pkg::SCORE_W-1:0] eye_a[10] = '{13, 14, 15, 15, 15, 15, 15, 15, 15, 0};
    logic [rpwf_pkg::SCORE_W-1:0] tie_b[6]  = '{15, 15, 0, 14, 15, 1};
    foreach (eye_a[i]) send_step(eye_a[i], i == 9);
    foreach (tie_b[i]) send_step(tie_b[i], i == 5);
    send_step(4'd15, 1'b1);
  endtask

  // Threshold zero keeps every run open; threshold fifteen needs full scores.
  task automatic test_threshold_extremes();
    apply_config(4'd0, 8'd8, rpwf_pkg::PERFECT_RST);
    send_step(4'd0, 1'b0);
    send_step(4'd15, 1'b1);
    apply_config(4'd15, 8'd1, rpwf_pkg::PERFECT_RST);
    send_step(4'd14, 1'b0);
    send_step(4'd15, 1'b0);
    send_step(4'd15, 1'b0);
    send_step(4'd14, 1'b1);
  endtask

  // Matching the perfect total overrides a window; zero total matches zero.
  task automatic test_simulation_verdict();
    logic [rpwf_pkg::CFG_DAT_W-1:0] w;
    apply_config(rpwf_pkg::THRESHOLD_RST, rpwf_pkg::MIN_WINDOW_RST, 12'd30);
    send_step(4'd15, 1'b0);
    send_step(4'd15, 1'b0);
    send_step(4'd0, 1'b1);
    apply_config(rpwf_pkg::THRESHOLD_RST, rpwf_pkg::MIN_WINDOW_RST, 12'd0);
    send_step(4'd0, 1'b1);
    // A write to the unused index must leave every register alone.
    settle();
    w = rpwf_pkg::CFG_DAT_W'($urandom);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_SPARE;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
    send_step(4'd0, 1'b1);
  endtask

  // Full-length sweeps: the forced end at the last phase, the widest window
  // possible, and the maximum sum.
  task automatic test_full_sweeps();
    apply_config(rpwf_pkg::THRESHOLD_RST, rpwf_pkg::MIN_WINDOW_RST, rpwf_pkg::PERFECT_RST);
    repeat (rpwf_pkg::PHASES) send_step(4'd15, 1'b0);
    apply_config(4'd8, 8'd255, 12'd3825);
    send_eye_sweep(rpwf_pkg::PHASES, 1'b0, 1'b0);
    apply_config(rpwf_pkg::THRESHOLD_RST, 8'd0, 12'd3825);
    for (int i = 0; i < rpwf_pkg::PHASES; i++)
      send_step(i == rpwf_pkg::PHASES - 1 ? 4'd0 : 4'd15, i == rpwf_pkg::PHASES - 1);
  endtask

  // Random sweeps under several settings, extremes first.
  task automatic test_random_sweeps();
    int start_count;
    int len;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: apply_config(rpwf_pkg::THRESHOLD_RST, rpwf_pkg::MIN_WINDOW_RST,
                        rpwf_pkg::PERFECT_RST);
        1: apply_config(4'd0, 8'd0, 12'd0);
        2: apply_config(4'd15, 8'd255, 12'd3825);
        default: apply_config(rpwf_pkg::SCORE_W'($urandom_range(1, 15)),
                              rpwf_pkg::PHASE_W'($urandom_range(0, 20)),
                              rpwf_pkg::SUM_W'($urandom_range(0, 250)));
      endcase
      start_count = steps_sent;
      while (steps_sent - start_count < 130) begin
        steady_feed = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 14) == 0) len = $urandom_range(60, rpwf_pkg::PHASES);
        else len = $urandom_range(1, 30);
        if ($urandom_range(0, 9) == 0)
          send_eye_sweep($urandom_range(1, rpwf_pkg::PHASES + 10), 1'b1, 1'($urandom));
        else
          send_eye_sweep(len, 1'b0, len == rpwf_pkg::PHASES ? 1'($urandom) : 1'b1);
        // Now and then hold off until the result side has drained.
        if ($urandom_range(0, 11) == 0) settle();
      end
      steady_feed = 1'b0;
      close_sweep();
    end
  endtask

  // Result side pacing: bursts of ready, short stalls, and now and then a
  // long stall or a long stretch with no stall at all.
  always @(posedge clk) begin
    if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else begin
      sink_pick = $urandom_range(0, 99);
      if (sink_pick < 45) begin
        out_ready <= 1'b1;
        sink_left <= $urandom_range(0, 8);
      end else if (sink_pick < 85) begin
        out_ready <= 1'b0;
        sink_left <= $urandom_range(0, 3);
      end else if (sink_pick < 95) begin
        out_ready <= 1'b1;
        sink_left <= $urandom_range(40, 150);
      end else begin
        out_ready <= 1'b0;
        sink_left <= $urandom_range(15, 60);
      end
    end
  end

  // Check every result transaction against the oldest expected one.
  always @(posedge clk) begin : check_results
    rpwf_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict %0d center %0d length %0d total %0d",
                   out_verdict, out_center_phase, out_window_length, out_total_score);
      end else begin
        want = pending_results.pop_front();
        sweeps_graded++;
        verdict_hits[want.verdict]++;
        if (out_verdict !== want.verdict || out_center_phase !== want.center_phase ||
            out_window_length !== want.window_length ||
            out_total_score !== want.total_score) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.verdict, want.center_phase, want.window_length,
                     want.total_score, out_verdict, out_center_phase,
                     out_window_length, out_total_score);
        end
      end
    end
  end

  initial begin
    foreach (verdict_hits[i]) verdict_hits[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_threshold_extremes();
    test_simulation_verdict();
    test_full_sweeps();
    test_random_sweeps();
    settle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
    $display("ran %0d phase steps in %0d graded sweeps over %0d register writes",
             steps_sent, sweeps_graded, cfg_writes);
    $display("verdicts: no window %0d, too narrow %0d, accepted %0d, simulation %0d",
             verdict_hits[rpwf_pkg::VERDICT_NO_WINDOW],
             verdict_hits[rpwf_pkg::VERDICT_TOO_NARROW],
             verdict_hits[rpwf_pkg::VERDICT_ACCEPTED],
             verdict_hits[rpwf_pkg::VERDICT_SIMULATION]);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
